/* design/cbsg_pkg.sv */
package cbsg_pkg;

  localparam int LOC_W      = 15;
  localparam int CNT_W      = 17;
  localparam int STEP_W     = 19;
  localparam int PROD_W     = LOC_W + STEP_W;
  localparam int COLB_W     = 17;
  localparam int OUT_ADDR_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BUF_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BUF_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDR  = 3'd7;

  localparam logic [1:0] DEPTH_16   = 2'd0;
  localparam logic [1:0] DEPTH_24   = 2'd1;
  localparam logic [1:0] DEPTH_32   = 2'd2;
  localparam logic [1:0] DEPTH_NONE = 2'd3;

  localparam logic [1:0] EDGE_TOP    = 2'd0;
  localparam logic [1:0] EDGE_BOTTOM = 2'd1;
  localparam logic [1:0] EDGE_LEFT   = 2'd2;
  localparam logic [1:0] EDGE_RIGHT  = 2'd3;

  localparam logic [31:0] RED_16 = 32'h0000_F800;
  localparam logic [31:0] RED_24 = 32'h0000_00FF;
  localparam logic [31:0] RED_32 = 32'hFFFF_0000;

  // sides bit n set means the edge of kind n survived clipping
  typedef struct packed {
    logic [3:0]       sides;
    logic [LOC_W-1:0] lx1;
    logic [LOC_W-1:0] lx2;
    logic [LOC_W-1:0] ly1;
    logic [LOC_W-1:0] ly2;
    logic [CNT_W-1:0] hcount;
    logic [CNT_W-1:0] vcount;
  } rect_entry_t;

  typedef struct packed {
    logic [STEP_W-1:0]     stride;
    logic [2:0]            bpp;
    logic [31:0]           color;
    logic [OUT_ADDR_W-1:0] base;
  } span_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [2:0] depth_bpp(input logic [1:0] mode);
    logic [2:0] b;
    case (mode)
      DEPTH_16: b = 3'd2;
      DEPTH_24: b = 3'd3;
      DEPTH_32: b = 3'd4;
      default:  b = 3'd0;
    endcase
    return b;
  endfunction

  function automatic logic [31:0] depth_color(input logic [1:0] mode);
    logic [31:0] c;
    case (mode)
      DEPTH_16: c = RED_16;
      DEPTH_24: c = RED_24;
      DEPTH_32: c = RED_32;
      default:  c = '0;
    endcase
    return c;
  endfunction

endpackage

/* design/clipped_border_span_generator_top.sv */
// Channel   Direction  Handshake            Payload
// ------    ---------  -------------------  ------------------------------------------
// rect      in         start & !busy        rect_left/top/right/bottom
// span      out        span_valid (1 cycle) start_address, step_bytes, pixel_count,
//                                           pixel_bytes, fill_color, edge_kind, last_span
// config    in         cfg_write            cfg_index, cfg_data
//
// A rectangle yields one span per surviving edge (1 to 4); one with no spans is dropped
// in the front end. The span sequencer in the back end issues one span per clock.
// Span path: front hold register, queue, back current register, issue and output stages.
// rst is synchronous: it clears control state and all config registers (all zero).
// The span receiver cannot stall; busy rises only when the two-deep rectangle queue
// is full and the front end holds a rectangle that it does not drop.
module clipped_border_span_generator_top import cbsg_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int ADDR_BITS  = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_BITS-1:0]  rect_left,
  input  logic [COORD_BITS-1:0]  rect_top,
  input  logic [COORD_BITS-1:0]  rect_right,
  input  logic [COORD_BITS-1:0]  rect_bottom,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   span_valid,
  output logic [OUT_ADDR_W-1:0]  start_address,
  output logic [STEP_W-1:0]      step_bytes,
  output logic [CNT_W-1:0]       pixel_count,
  output logic [2:0]             pixel_bytes,
  output logic [31:0]            fill_color,
  output logic [1:0]             edge_kind,
  output logic                   last_span
);

  localparam int CW = COORD_BITS;
  localparam int AW = (ADDR_BITS < OUT_ADDR_W) ? ADDR_BITS : OUT_ADDR_W;

  logic [CW-1:0]         win_left, win_top, win_right, win_bottom;
  logic [LOC_W-1:0]      buf_width, buf_height;
  logic [1:0]            depth_mode;
  logic [OUT_ADDR_W-1:0] base_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left     <= '0;
      win_top      <= '0;
      win_right    <= '0;
      win_bottom   <= '0;
      buf_width    <= '0;
      buf_height   <= '0;
      depth_mode   <= DEPTH_16;
      base_address <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIN_LEFT:   win_left     <= cfg_data[CW-1:0];
        REG_WIN_TOP:    win_top      <= cfg_data[CW-1:0];
        REG_WIN_RIGHT:  win_right    <= cfg_data[CW-1:0];
        REG_WIN_BOTTOM: win_bottom   <= cfg_data[CW-1:0];
        REG_BUF_WIDTH:  buf_width    <= cfg_data[LOC_W-1:0];
        REG_BUF_HEIGHT: buf_height   <= cfg_data[LOC_W-1:0];
        REG_DEPTH_MODE: depth_mode   <= cfg_data[1:0];
        REG_BASE_ADDR:  base_address <= cfg_data[OUT_ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // row stride = window columns * bytes per pixel
  logic signed [CW+1:0] win_span;
  logic [CNT_W-1:0]     win_cols;
  logic [STEP_W-1:0]    stride;
  logic                 cfg_ok;
  span_cfg_t            span_cfg;

  assign win_span = (CW+2)'(signed'(win_right)) - (CW+2)'(signed'(win_left)) + (CW+2)'(1);
  assign win_cols = CNT_W'(win_span);

  always_comb begin
    case (depth_mode)
      DEPTH_16: stride = STEP_W'({win_cols, 1'b0});
      DEPTH_24: stride = STEP_W'({win_cols, 1'b0}) + STEP_W'(win_cols);
      DEPTH_32: stride = STEP_W'({win_cols, 2'b00});
      default:  stride = '0;
    endcase
  end

  assign cfg_ok          = (depth_mode != DEPTH_NONE) && (base_address != '0);
  assign span_cfg.stride = stride;
  assign span_cfg.bpp    = depth_bpp(depth_mode);
  assign span_cfg.color  = depth_color(depth_mode);
  assign span_cfg.base   = base_address;

  logic        front_push, q_pop;
  rect_entry_t front_entry, q_head;
  q_stat_t     q_stat;

  cbsg_front #(.CW(CW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .rect_left  (rect_left),
    .rect_top   (rect_top),
    .rect_right (rect_right),
    .rect_bottom(rect_bottom),
    .win_left   (win_left),
    .win_top    (win_top),
    .win_right  (win_right),
    .win_bottom (win_bottom),
    .buf_width  (buf_width),
    .buf_height (buf_height),
    .cfg_ok     (cfg_ok),
    .q_stat     (q_stat),
    .push       (front_push),
    .push_entry (front_entry)
  );

  cbsg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_entry(front_entry),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  cbsg_back #(.AW(AW)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .q_stat       (q_stat),
    .pop          (q_pop),
    .cfg          (span_cfg),
    .span_valid   (span_valid),
    .start_address(start_address),
    .step_bytes   (step_bytes),
    .pixel_count  (pixel_count),
    .pixel_bytes  (pixel_bytes),
    .fill_color   (fill_color),
    .edge_kind    (edge_kind),
    .last_span    (last_span)
  );

  // spans of one rectangle leave on consecutive cycles in edge order
  a_span_burst: assert property (@(posedge clk) disable iff (rst)
    span_valid && !last_span |=> span_valid && (edge_kind > $past(edge_kind)))
    else $error("span burst broken or out of order");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    front_push |-> !q_stat.full)
    else $error("push into full rect queue");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    span_valid |-> pixel_count != '0)
    else $error("span with zero pixels");

  a_row_step: assert property (@(posedge clk) disable iff (rst)
    span_valid && (edge_kind == EDGE_TOP || edge_kind == EDGE_BOTTOM)
      |-> step_bytes == STEP_W'(pixel_bytes))
    else $error("row span step is not pixel size");

endmodule

/* design/cbsg_front.sv */
module cbsg_front import cbsg_pkg::*; #(
  parameter int CW = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [CW-1:0]    rect_left,
  input  logic [CW-1:0]    rect_top,
  input  logic [CW-1:0]    rect_right,
  input  logic [CW-1:0]    rect_bottom,
  input  logic [CW-1:0]    win_left,
  input  logic [CW-1:0]    win_top,
  input  logic [CW-1:0]    win_right,
  input  logic [CW-1:0]    win_bottom,
  input  logic [LOC_W-1:0] buf_width,
  input  logic [LOC_W-1:0] buf_height,
  input  logic             cfg_ok,
  input  q_stat_t          q_stat,
  output logic             push,
  output rect_entry_t      push_entry
);

  logic          hold_valid;
  logic [CW-1:0] hold_left, hold_top, hold_right, hold_bottom;

  logic signed [CW-1:0] rl, rt, rr, rb, wl, wt, wr, wb;
  logic signed [CW-1:0] vx1, vy1, vx2, vy2;
  logic signed [17:0]   lx1, ly1, lx2, ly2, bw, bh;
  logic                 empty, outside, no_side, drop, done, take;

  assign rl = signed'(hold_left);
  assign rt = signed'(hold_top);
  assign rr = signed'(hold_right);
  assign rb = signed'(hold_bottom);
  assign wl = signed'(win_left);
  assign wt = signed'(win_top);
  assign wr = signed'(win_right);
  assign wb = signed'(win_bottom);

  always_comb begin
    vx1 = (rl > wl) ? rl : wl;
    vy1 = (rt > wt) ? rt : wt;
    vx2 = (rr < wr) ? rr : wr;
    vy2 = (rb < wb) ? rb : wb;
    // local coordinates, exact
    lx1 = 18'(vx1) - 18'(wl);
    ly1 = 18'(vy1) - 18'(wt);
    lx2 = 18'(vx2) - 18'(wl);
    ly2 = 18'(vy2) - 18'(wt);
    bw  = signed'({3'b000, buf_width});
    bh  = signed'({3'b000, buf_height});
    empty   = (vx1 > vx2) || (vy1 > vy2);
    outside = (lx2 >= bw) || (ly2 >= bh);
    // clipped on all four sides: the outline lies outside the window
    no_side = (vx1 != rl) && (vx2 != rr) && (vy1 != rt) && (vy2 != rb);
    drop    = !cfg_ok || empty || outside || no_side;
  end

  assign done = hold_valid && (drop || !q_stat.full);
  assign busy = hold_valid && !done;
  assign take = start && !busy;
  assign push = hold_valid && !drop && !q_stat.full;

  always_comb begin
    push_entry.sides  = {vx2 == rr, vx1 == rl, vy2 == rb, vy1 == rt};
    push_entry.lx1    = LOC_W'(lx1);
    push_entry.lx2    = LOC_W'(lx2);
    push_entry.ly1    = LOC_W'(ly1);
    push_entry.ly2    = LOC_W'(ly2);
    push_entry.hcount = CNT_W'(lx2 - lx1 + 18'sd1);
    push_entry.vcount = CNT_W'(ly2 - ly1 + 18'sd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (done) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_left   <= rect_left;
      hold_top    <= rect_top;
      hold_right  <= rect_right;
      hold_bottom <= rect_bottom;
    end
  end

endmodule

/* design/cbsg_queue.sv */
module cbsg_queue import cbsg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  rect_entry_t push_entry,
  input  logic        pop,
  output rect_entry_t head,
  output q_stat_t     stat
);

  rect_entry_t        slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign head       = slots[rd_ptr];
  assign stat.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (count == '0);

  function automatic logic [Q_PTR_W-1:0] bump(input logic [Q_PTR_W-1:0] p);
    return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

/* design/cbsg_back.sv */
module cbsg_back import cbsg_pkg::*; #(
  parameter int AW = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rect_entry_t           head,
  input  q_stat_t               q_stat,
  output logic                  pop,
  input  span_cfg_t             cfg,
  output logic                  span_valid,
  output logic [OUT_ADDR_W-1:0] start_address,
  output logic [STEP_W-1:0]     step_bytes,
  output logic [CNT_W-1:0]      pixel_count,
  output logic [2:0]            pixel_bytes,
  output logic [31:0]           fill_color,
  output logic [1:0]            edge_kind,
  output logic                  last_span
);

  logic        cur_valid;
  rect_entry_t cur;
  logic [3:0]  rem, low, rem_left;
  logic [1:0]  kind;
  logic        is_column, load;
  logic [LOC_W-1:0] row, col;

  // one span per cycle, lowest remaining edge first
  assign low      = rem & (~rem + 4'd1);
  assign rem_left = rem & ~low;
  assign load     = !q_stat.empty && (!cur_valid || rem_left == 4'd0);
  assign pop      = load;

  always_comb begin
    case (low)
      4'b0001: kind = EDGE_TOP;
      4'b0010: kind = EDGE_BOTTOM;
      4'b0100: kind = EDGE_LEFT;
      default: kind = EDGE_RIGHT;
    endcase
    is_column = (kind == EDGE_LEFT) || (kind == EDGE_RIGHT);
    row = (kind == EDGE_BOTTOM) ? cur.ly2 : cur.ly1;
    col = (kind == EDGE_RIGHT) ? cur.lx2 : cur.lx1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (load) begin
      cur_valid <= 1'b1;
    end else if (cur_valid && rem_left == 4'd0) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= head;
      rem <= head.sides;
    end else if (cur_valid) begin
      rem <= rem_left;
    end
  end

  // issue stage: row offset and column byte offset multiplies
  logic              s1_valid, s1_column, s1_last;
  logic [PROD_W-1:0] s1_prod;
  logic [COLB_W-1:0] s1_colb;
  logic [CNT_W-1:0]  s1_count;
  logic [1:0]        s1_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_prod   <= PROD_W'(row) * PROD_W'(cfg.stride);
    s1_colb   <= COLB_W'(col) * COLB_W'(cfg.bpp);
    s1_count  <= is_column ? cur.vcount : cur.hcount;
    s1_kind   <= kind;
    s1_column <= is_column;
    s1_last   <= (rem_left == 4'd0);
  end

  // output stage: address sum wraps at AW bits
  logic [AW-1:0] addr;
  assign addr = AW'(cfg.base) + AW'(s1_prod) + AW'(s1_colb);

  always_ff @(posedge clk) begin
    if (rst) begin
      span_valid <= 1'b0;
    end else begin
      span_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    start_address <= OUT_ADDR_W'(addr);
    step_bytes    <= s1_column ? cfg.stride : STEP_W'(cfg.bpp);
    pixel_count   <= s1_count;
    pixel_bytes   <= cfg.bpp;
    fill_color    <= cfg.color;
    edge_kind     <= s1_kind;
    last_span     <= s1_last;
  end

endmodule

/* verif/tb_clipped_border_span_generator_top.sv */
`timescale 1ns / 100ps

module tb_clipped_border_span_generator_top;
  import cbsg_pkg::*;

  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [31:0] addr;
    logic [18:0] step;
    logic [16:0] count;
    logic [2:0]  bpp;
    logic [31:0] color;
    logic [1:0]  kind;
    logic        last;
  } span_t;

  class outline_span_checker;
    logic [15:0] win_left, win_top, win_right, win_bottom;
    logic [14:0] buf_width, buf_height;
    logic [1:0]  depth_mode;
    logic [31:0] base_addr;
    span_t       pending_spans[$];
    int          errors, rects, spans;
    int          kind_seen[4];

    function new();
      win_left = '0; win_top = '0; win_right = '0; win_bottom = '0;
      buf_width = '0; buf_height = '0; depth_mode = DEPTH_16; base_addr = '0;
      errors = 0; rects = 0; spans = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function void load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
      case (idx)
        REG_WIN_LEFT:   win_left   = data[15:0];
        REG_WIN_TOP:    win_top    = data[15:0];
        REG_WIN_RIGHT:  win_right  = data[15:0];
        REG_WIN_BOTTOM: win_bottom = data[15:0];
        REG_BUF_WIDTH:  buf_width  = data[14:0];
        REG_BUF_HEIGHT: buf_height = data[14:0];
        REG_DEPTH_MODE: depth_mode = data[1:0];
        REG_BASE_ADDR:  base_addr  = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_spans.size();
    endfunction

    // clip against the window and queue the surviving outline sides
    function void predict_outline_spans(input logic [15:0] l, t, r, b);
      longint rl, rt, rr, rb, wl, wt, wr, wb;
      longint vx1, vy1, vx2, vy2, lx1, ly1, lx2, ly2;
      longint bpp, stride, hcount, vcount, base;
      logic [31:0] color;
      logic [3:0]  sides;
      span_t       s;
      rects++;
      rl = $signed(l); rt = $signed(t); rr = $signed(r); rb = $signed(b);
      wl = $signed(win_left); wt = $signed(win_top);
      wr = $signed(win_right); wb = $signed(win_bottom);
      if (base_addr == '0) return;
      vx1 = (rl > wl) ? rl : wl;
      vy1 = (rt > wt) ? rt : wt;
      vx2 = (rr < wr) ? rr : wr;
      vy2 = (rb < wb) ? rb : wb;
      if (vx1 > vx2 || vy1 > vy2) return;
      lx1 = vx1 - wl; ly1 = vy1 - wt;
      lx2 = vx2 - wl; ly2 = vy2 - wt;
      if (lx2 >= longint'(buf_width) || ly2 >= longint'(buf_height)) return;
      case (depth_mode)
        DEPTH_16: begin bpp = 2; color = RED_16; end
        DEPTH_24: begin bpp = 3; color = RED_24; end
        DEPTH_32: begin bpp = 4; color = RED_32; end
        default: return;
      endcase
      stride = (wr - wl + 1) * bpp;
      base   = longint'(base_addr);
      hcount = lx2 - lx1 + 1;
      vcount = ly2 - ly1 + 1;
      sides  = {vx2 == rr, vx1 == rl, vy2 == rb, vy1 == rt};
      for (int k = 0; k < 4; k++) begin
        if (sides[k]) begin
          s.bpp   = 3'(bpp);
          s.color = color;
          s.kind  = 2'(k);
          s.last  = ((sides >> (k + 1)) == 4'd0);
          case (2'(k))
            EDGE_TOP: begin
              s.addr = 32'(base + ly1 * stride + lx1 * bpp);
              s.step = 19'(bpp); s.count = 17'(hcount);
            end
            EDGE_BOTTOM: begin
              s.addr = 32'(base + ly2 * stride + lx1 * bpp);
              s.step = 19'(bpp); s.count = 17'(hcount);
            end
            EDGE_LEFT: begin
              s.addr = 32'(base + ly1 * stride + lx1 * bpp);
              s.step = 19'(stride); s.count = 17'(vcount);
            end
            default: begin
              s.addr = 32'(base + ly1 * stride + lx2 * bpp);
              s.step = 19'(stride); s.count = 17'(vcount);
            end
          endcase
          pending_spans.push_back(s);
        end
      end
    endfunction

    task report_mismatch(input string what);
      $display("ERROR %0t: %s", $time, what);
      errors++;
    endtask

    task check_span(input span_t got);
      span_t want;
      spans++;
      kind_seen[got.kind]++;
      if (pending_spans.size() == 0) begin
        report_mismatch($sformatf("span beat with nothing pending: kind %0d addr %08h",
                                  got.kind, got.addr));
      end else begin
        want = pending_spans.pop_front();
        if (got.addr != want.addr)
          report_mismatch($sformatf("start_address %08h, want %08h", got.addr, want.addr));
        if (got.step != want.step)
          report_mismatch($sformatf("step_bytes %0d, want %0d", got.step, want.step));
        if (got.count != want.count)
          report_mismatch($sformatf("pixel_count %0d, want %0d", got.count, want.count));
        if (got.bpp != want.bpp)
          report_mismatch($sformatf("pixel_bytes %0d, want %0d", got.bpp, want.bpp));
        if (got.color != want.color)
          report_mismatch($sformatf("fill_color %08h, want %08h", got.color, want.color));
        if (got.kind != want.kind)
          report_mismatch($sformatf("edge_kind %0d, want %0d", got.kind, want.kind));
        if (got.last != want.last)
          report_mismatch($sformatf("last_span %0b, want %0b", got.last, want.last));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [15:0]           rect_left = '0;
  logic [15:0]           rect_top = '0;
  logic [15:0]           rect_right = '0;
  logic [15:0]           rect_bottom = '0;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_WIN_LEFT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  span_valid;
  logic [OUT_ADDR_W-1:0] start_address;
  logic [STEP_W-1:0]     step_bytes;
  logic [CNT_W-1:0]      pixel_count;
  logic [2:0]            pixel_bytes;
  logic [31:0]           fill_color;
  logic [1:0]            edge_kind;
  logic                  last_span;

  outline_span_checker sb;
  span_t               seen_span;
  int                  quiet_cycles = 0;
  int                  settings = 0;

  clipped_border_span_generator_top i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && span_valid) begin
      seen_span.addr  = start_address;
      seen_span.step  = step_bytes;
      seen_span.count = pixel_count;
      seen_span.bpp   = pixel_bytes;
      seen_span.color = fill_color;
      seen_span.kind  = edge_kind;
      seen_span.last  = last_span;
      sb.check_span(seen_span);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || span_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles with no beat, %0d spans outstanding",
               WATCHDOG_LIMIT, sb.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [15:0] clamp16(input longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  task automatic send_rect(input logic [15:0] l, t, r, b);
    @(negedge clk);
    start       <= 1'b1;
    rect_left   <= l;
    rect_top    <= t;
    rect_right  <= r;
    rect_bottom <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.predict_outline_spans(l, t, r, b);
  endtask

  task automatic pause_sender(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // drain every pending span, then give rectangles with no spans time to clear
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.load_reg(idx, data);
  endtask

  // unused upper data bits carry noise; the block must ignore them
  task automatic write_config(input longint wl, wt, wr, wb, bw, bh,
                              input logic [1:0] depth, input logic [31:0] base);
    settle();
    write_reg(REG_WIN_LEFT,   {16'($urandom), 16'(wl)});
    write_reg(REG_WIN_TOP,    {16'($urandom), 16'(wt)});
    write_reg(REG_WIN_RIGHT,  {16'($urandom), 16'(wr)});
    write_reg(REG_WIN_BOTTOM, {16'($urandom), 16'(wb)});
    write_reg(REG_BUF_WIDTH,  {17'($urandom), 15'(bw)});
    write_reg(REG_BUF_HEIGHT, {17'($urandom), 15'(bh)});
    write_reg(REG_DEPTH_MODE, {30'($urandom), depth});
    write_reg(REG_BASE_ADDR,  base);
    @(negedge clk);
    cfg_write <= 1'b0;
    settings++;
  endtask

  // mostly rectangles around the window so that each side gets clipped or kept
  task automatic gen_rect(output logic [15:0] l, t, r, b);
    longint wl, wt, w, h, x, y, span_w, span_h;
    int     sel;
    wl = $signed(sb.win_left);
    wt = $signed(sb.win_top);
    w  = longint'($signed(sb.win_right)) - wl + 1;
    h  = longint'($signed(sb.win_bottom)) - wt + 1;
    if (w < 1) w = 64;
    if (h < 1) h = 64;
    span_w = (w > 300) ? 300 : w;
    span_h = (h > 300) ? 300 : h;
    sel = $urandom_range(0, 15);
    if (sel == 0) begin
      l = 16'($urandom); t = 16'($urandom); r = 16'($urandom); b = 16'($urandom);
    end else begin
      x = wl - 8 + longint'($urandom_range(0, 32'(w + 15)));
      y = wt - 8 + longint'($urandom_range(0, 32'(h + 15)));
      l = clamp16(x);
      t = clamp16(y);
      r = clamp16(x + longint'($urandom_range(0, 32'(span_w + 8))) - 2);
      b = clamp16(y + longint'($urandom_range(0, 32'(span_h + 8))) - 2);
      case (sel)
        1: r = clamp16(x - longint'($urandom_range(1, 40)));
        2: r = l;
        3: b = t;
        4: begin r = l; b = t; end
        default: ;
      endcase
    end
  endtask

  task automatic run_rects(input int n, input bit steady);
    int          burst = 0;
    int          gap;
    logic [15:0] l, t, r, b;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) pause_sender(gap);
        burst = $urandom_range(1, 12);
      end
      gen_rect(l, t, r, b);
      send_rect(l, t, r, b);
      burst--;
    end
  endtask

  initial begin
    longint      wl, wt, wr, wb, w, h, bw, bh;
    logic [1:0]  depth;
    logic [31:0] base;
    int          flavor;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers at reset: zero base means no buffer
    send_rect(16'd30, 16'd30, 16'd50, 16'd40);

    write_config(10, 20, 109, 79, 100, 60, DEPTH_16, 32'h2000_0000);
    send_rect(16'd30, 16'd30, 16'd50, 16'd40);
    send_rect(16'd10, 16'd20, 16'd109, 16'd79);
    send_rect(16'd0, 16'd0, 16'd200, 16'd200);
    send_rect(16'd5, 16'd30, 16'd50, 16'd40);
    send_rect(16'd30, 16'd30, 16'd150, 16'd40);
    send_rect(16'd30, 16'd10, 16'd50, 16'd40);
    send_rect(16'd30, 16'd30, 16'd50, 16'd100);
    send_rect(16'd50, 16'd30, 16'd40, 16'd40);
    send_rect(16'd30, 16'd40, 16'd50, 16'd30);
    send_rect(16'd30, 16'd35, 16'd60, 16'd35);
    send_rect(16'd45, 16'd25, 16'd45, 16'd70);
    send_rect(16'd60, 16'd50, 16'd60, 16'd50);
    send_rect(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_rect(16'h8000, 16'd30, 16'd20, 16'd40);
    send_rect(16'd100, 16'd30, 16'h7FFF, 16'd40);
    send_rect(16'd200, 16'd200, 16'd300, 16'd300);
    send_rect(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_rect(16'd30, 16'h8000, 16'd50, 16'h7FFF);

    write_config(10, 20, 109, 79, 100, 60, DEPTH_NONE, 32'h2000_0000);
    send_rect(16'd30, 16'd30, 16'd50, 16'd40);
    write_config(10, 20, 109, 79, 100, 60, DEPTH_24, 32'h0001_0003);
    send_rect(16'd5, 16'd30, 16'd50, 16'd40);
    // buffer narrower and shorter than the window
    write_config(10, 20, 109, 79, 50, 30, DEPTH_32, 32'h8000_0000);
    send_rect(16'd30, 16'd30, 16'd50, 16'd40);
    send_rect(16'd30, 16'd30, 16'd80, 16'd40);
    send_rect(16'd30, 16'd30, 16'd50, 16'd60);
    // window with right edge left of left edge
    write_config(10, 20, 5, 79, 100, 60, DEPTH_16, 32'h2000_0000);
    send_rect(16'd0, 16'd0, 16'd50, 16'd50);

    for (int p = 0; p < 12; p++) begin
      flavor = p % 6;
      w  = $urandom_range(1, 160);
      h  = $urandom_range(1, 120);
      wl = longint'($urandom_range(0, 600)) - 300;
      wt = longint'($urandom_range(0, 600)) - 300;
      bw = w + $urandom_range(0, 3);
      bh = h + $urandom_range(0, 3);
      depth = 2'($urandom_range(0, 2));
      base  = $urandom;
      if (base == '0) base = 32'h1;
      case (flavor)
        1: begin
          bw = $urandom_range(1, 32'(w));
          bh = $urandom_range(1, 32'(h));
        end
        2: begin
          wl = -32768; wt = -32768; w = 65536; h = 65536;
          bw = 32767; bh = 32767; depth = DEPTH_32;
        end
        4: begin
          if (p == 4) w = 1;
          wl = 32767 - w + 1;
          wt = -32768;
        end
        5: base = 32'hFFFF_FFFF - $urandom_range(0, 255);
        default: ;
      endcase
      wr = wl + w - 1;
      wb = wt + h - 1;
      if (flavor == 3) begin
        if (p == 3) begin
          wr = wl - $urandom_range(1, 50);
          bw = 0;
        end else begin
          depth = DEPTH_NONE;
        end
      end
      write_config(wl, wt, wr, wb, bw, bh, depth, base);
      run_rects((flavor == 3) ? 12 : 29, (p % 4) == 1);
    end

    settle();
    $display("ran %0d rectangles over %0d register settings, %0d spans checked",
             sb.rects, settings, sb.spans);
    $display("spans per side: top %0d, bottom %0d, left %0d, right %0d",
             sb.kind_seen[EDGE_TOP], sb.kind_seen[EDGE_BOTTOM],
             sb.kind_seen[EDGE_LEFT], sb.kind_seen[EDGE_RIGHT]);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/cbsg_pkg.sv
design/cbsg_front.sv
design/cbsg_queue.sv
design/cbsg_back.sv
design/clipped_border_span_generator_top.sv
verif/tb_clipped_border_span_generator_top.sv
